/* src/someip_header_deframer_core_assert.svh */
// Assertion macros for the SOME/IP header deframer core.
`ifndef SOMEIP_HEADER_DEFRAMER_CORE_ASSERT_SVH
`define SOMEIP_HEADER_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SHD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define SHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHD_ASSERT_NOW(lbl, ante, cons, msg)
`define SHD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* src/someip_hdr_pkg.sv */
// Types, constants and helpers shared by the SOME/IP header deframer.
package someip_hdr_pkg;

  localparam int HDR_BYTES      = 16;
  localparam int HDR_IDX_W      = $clog2(HDR_BYTES);
  localparam int POS_W          = 33;
  localparam int LEN_W          = 32;
  localparam int LEN_BIAS       = 8;
  localparam int OUT_FIFO_DEPTH = 4;

  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // protocol version register reset value
  localparam logic [7:0] PROTO_VER_RST = 8'h01;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT_HDR = 3'd1,
    ST_LEN_LOW   = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_BAD_VER   = 3'd4,
    ST_BAD_TYPE  = 3'd5
  } status_t;

  // defined message type codes
  localparam logic [7:0] MT_REQUEST          = 8'h00;
  localparam logic [7:0] MT_REQUEST_NO_RET   = 8'h01;
  localparam logic [7:0] MT_NOTIFICATION     = 8'h02;
  localparam logic [7:0] MT_TP_REQUEST       = 8'h20;
  localparam logic [7:0] MT_TP_REQUEST_NORET = 8'h21;
  localparam logic [7:0] MT_TP_NOTIFICATION  = 8'h22;
  localparam logic [7:0] MT_RESPONSE         = 8'h80;
  localparam logic [7:0] MT_ERROR            = 8'h81;
  localparam logic [7:0] MT_TP_RESPONSE      = 8'hA0;
  localparam logic [7:0] MT_TP_ERROR         = 8'hA1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic             result_kind;
    logic [7:0]       payload_byte;
    logic [15:0]      srv_id;
    logic [15:0]      mth_id;
    logic [15:0]      cli_id;
    logic [15:0]      sess_id;
    logic [7:0]       if_ver;
    logic [7:0]       msg_type;
    logic [7:0]       ret_code;
    logic [LEN_W-1:0] body_len;
    status_t          status;
    logic             last;
  } out_beat_t;

  // results produced by one byte: first slot always used before second
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic logic type_known(input logic [7:0] t);
    logic ok;
    case (t)
      MT_REQUEST, MT_REQUEST_NO_RET, MT_NOTIFICATION,
      MT_TP_REQUEST, MT_TP_REQUEST_NORET, MT_TP_NOTIFICATION,
      MT_RESPONSE, MT_ERROR, MT_TP_RESPONSE, MT_TP_ERROR: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

/* src/someip_header_deframer_core.sv */
// Top level of the SOME/IP header deframer: input stage, parser and result queue.
//
// Takes one buffer byte per beat on the in_ channel and captures the 16-byte
// big-endian SOME/IP header. Bytes after the header come out as payload beats
// (result_kind 1) until the length field minus 8 is used up; later bytes are
// dropped. The beat flagged last_byte always yields one status beat
// (result_kind 0, last 1) with the header fields, payload length and a
// numbered verdict, after that byte's own payload beat if it has one; the
// parser then clears for the next buffer. Rate: one byte per cycle sustained
// while the result queue has room. A byte is registered in the input register
// and then written into the result queue, from which out_ is read directly.
// The final byte of a frame may yield two beats, so the output
// side must pop one beat more for it; the input register holds its byte
// while the result queue has fewer than two free entries, which with the
// default depth of four never stalls the input while out_stall stays low.
// cfg_ready is always high; the protocol version register resets to 1.
module someip_header_deframer_core
  import someip_hdr_pkg::*;
#(
  parameter int FIFO_DEPTH = OUT_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  // byte input
  input  logic       in_valid,
  output logic       in_stall,
  input  in_beat_t   in_data,
  // result output
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_data,
  // protocol version register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

`include "someip_header_deframer_core_assert.svh"

  localparam int LVL_W = $clog2(FIFO_DEPTH+1);

  logic             in_vld_r, in_vld_nxt;
  in_beat_t         in_beat_r;
  logic             in_acc;
  logic             take;
  logic             room;
  logic [LVL_W-1:0] level;
  logic [7:0]       proto_ver_r;
  push_t            push;
  out_beat_t        res_a, res_b;

  // input stage: held beat moves on when the queue has room for two
  assign take       = in_vld_r && room;
  assign in_stall   = in_vld_r && !room;
  assign in_acc     = in_valid && !in_stall;
  assign in_vld_nxt = in_acc || (in_vld_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_beat_r <= in_data;
    end
  end

  // config register, writable any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_ver_r <= PROTO_VER_RST;
    end else if (cfg_valid && cfg_ready) begin
      proto_ver_r <= cfg_data;
    end
  end

  someip_hdr_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .beat      (in_beat_r),
    .proto_ver (proto_ver_r),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b)
  );

  someip_hdr_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_a      (res_a),
    .wr_b      (res_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .room      (room),
    .level     (level)
  );

  // a byte held for lack of queue room is neither dropped nor altered
  `SHD_ASSERT_NEXT(a_hold_byte, in_vld_r && !room, in_vld_r && $stable(in_beat_r), "held byte lost")
  // the final byte of a buffer always produces a status beat
  `SHD_ASSERT_NOW(a_final_status, take && in_beat_r.last_byte, push.first, "no status beat")
  // the queue never overfills
  `SHD_ASSERT_NOW(a_no_overflow, 1'b1, level <= LVL_W'(FIFO_DEPTH), "result queue overflow")

endmodule

/* src/someip_hdr_parse.sv */
// Per-byte header capture, payload pass-through and frame verdict.
module someip_hdr_parse
  import someip_hdr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  in_beat_t   beat,
  input  logic [7:0] proto_ver,
  output push_t      push,
  output out_beat_t  res_a,
  output out_beat_t  res_b
);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc;
  logic [7:0]       hdr_r   [HDR_BYTES];
  logic [7:0]       hdr_nxt [HDR_BYTES];
  logic             in_hdr;
  logic [LEN_W-1:0] lf_cur, plen_cur, lf_new, plen_new;
  logic [POS_W-1:0] pay_pos;
  logic             pay_hit;
  status_t          st;
  out_beat_t        pay_res, stat_res;

  assign in_hdr  = pos_r < POS_W'(HDR_BYTES);
  assign pos_inc = (pos_r == {POS_W{1'b1}}) ? pos_r : pos_r + POS_W'(1);

  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_nxt[i] = hdr_r[i];
    end
    if (in_hdr) begin
      hdr_nxt[pos_r[HDR_IDX_W-1:0]] = beat.data_byte;
    end
  end

  // payload budget from the header as it stood before this byte
  assign lf_cur   = {hdr_r[4], hdr_r[5], hdr_r[6], hdr_r[7]};
  assign plen_cur = (lf_cur < LEN_W'(LEN_BIAS)) ? '0 : lf_cur - LEN_W'(LEN_BIAS);
  assign pay_pos  = pos_r - POS_W'(HDR_BYTES);
  assign pay_hit  = !in_hdr && (pay_pos < {1'b0, plen_cur});

  assign lf_new   = {hdr_nxt[4], hdr_nxt[5], hdr_nxt[6], hdr_nxt[7]};
  assign plen_new = (lf_new < LEN_W'(LEN_BIAS)) ? '0 : lf_new - LEN_W'(LEN_BIAS);

  always_comb begin
    if (pos_inc < POS_W'(HDR_BYTES)) begin
      st = ST_SHORT_HDR;
    end else if (lf_new < LEN_W'(LEN_BIAS)) begin
      st = ST_LEN_LOW;
    end else if ({1'b0, pos_inc} < ((POS_W+1)'(HDR_BYTES) + (POS_W+1)'(plen_new))) begin
      st = ST_TRUNC;
    end else if (hdr_nxt[12] != proto_ver) begin
      st = ST_BAD_VER;
    end else if (!type_known(hdr_nxt[14])) begin
      st = ST_BAD_TYPE;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    pay_res              = '0;
    pay_res.result_kind  = KIND_PAYLOAD;
    pay_res.payload_byte = beat.data_byte;
    pay_res.status       = ST_OK;

    stat_res             = '0;
    stat_res.result_kind = KIND_STATUS;
    stat_res.srv_id      = {hdr_nxt[0], hdr_nxt[1]};
    stat_res.mth_id      = {hdr_nxt[2], hdr_nxt[3]};
    stat_res.cli_id      = {hdr_nxt[8], hdr_nxt[9]};
    stat_res.sess_id     = {hdr_nxt[10], hdr_nxt[11]};
    stat_res.if_ver      = hdr_nxt[13];
    stat_res.msg_type    = hdr_nxt[14];
    stat_res.ret_code    = hdr_nxt[15];
    stat_res.body_len    = plen_new;
    stat_res.status      = st;
    stat_res.last        = 1'b1;
  end

  always_comb begin
    push.first  = take && (pay_hit || beat.last_byte);
    push.second = take && pay_hit && beat.last_byte;
    res_a       = pay_hit ? pay_res : stat_res;
    res_b       = stat_res;
  end

  assign pos_nxt = beat.last_byte ? '0 : pos_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr_r[i] <= '0;
      end
    end else if (take) begin
      pos_r <= pos_nxt;
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr_r[i] <= beat.last_byte ? 8'h00 : hdr_nxt[i];
      end
    end
  end

endmodule

/* src/someip_hdr_fifo.sv */
// Result queue: up to two beats in, one beat out per cycle while out_stall is low.
module someip_hdr_fifo
  import someip_hdr_pkg::*;
#(
  parameter int DEPTH = OUT_FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  push_t                      push,
  input  out_beat_t                  wr_a,
  input  out_beat_t                  wr_b,
  output logic                       out_valid,
  input  logic                       out_stall,
  output out_beat_t                  out_data,
  output logic                       room,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH+1);

  out_beat_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r, wr_nxt, rd_nxt, wr_1;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             pop;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH-1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign out_valid = level_r != '0;
  assign out_data  = mem[rd_r];
  assign pop       = out_valid && !out_stall;
  // two free slots, judged before this cycle's pop
  assign room      = level_r <= LVL_W'(DEPTH-2);
  assign level     = level_r;

  assign wr_1 = bump(wr_r);

  always_comb begin
    wr_nxt = wr_r;
    if (push.first && push.second) begin
      wr_nxt = bump(wr_1);
    end else if (push.first) begin
      wr_nxt = wr_1;
    end
    rd_nxt    = pop ? bump(rd_r) : rd_r;
    level_nxt = level_r + LVL_W'(push.first) + LVL_W'(push.second) - LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      level_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_r] <= wr_a;
    end
    if (push.second) begin
      mem[wr_1] <= wr_b;
    end
  end

endmodule
